@@ hw/rtl/tpa_pkg.sv @@
// shared types and constants for the timestamp pair aligner
`timescale 1ns / 1ps
`default_nettype none
package tpa_pkg;

  localparam int TOL_W     = 20;
  localparam int TIMEOUT_W = 16;
  localparam int LIMIT_W   = 9;
  localparam int FILL_W    = 9;
  localparam int CFG_W     = 20;
  localparam int REG_IDX_W = 2;

  localparam logic [TOL_W-1:0]     TOL_RESET     = 20'd2000;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 9'd200;
  localparam logic [TIMEOUT_W-1:0] IDLE_MAX      = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_PUSH_VIDEO = 2'd0,
    CMD_PUSH_META  = 2'd1,
    CMD_STEP       = 2'd2,
    CMD_TICK       = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OUT_MATCHED      = 3'd0,
    OUT_VIDEO_DROP   = 3'd1,
    OUT_META_DROP    = 3'd2,
    OUT_VIDEO_ALONE  = 3'd3,
    OUT_WAITING      = 3'd4,
    OUT_PUSHED       = 3'd5,
    OUT_PUSHED_DROP  = 3'd6,
    OUT_TICK         = 3'd7
  } outcome_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MATCH_TOL   = 2'd0,
    REG_TIMEOUT     = 2'd1,
    REG_QUEUE_LIMIT = 2'd2
  } reg_index_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } dp_cmd_t;

endpackage
`default_nettype wire

@@ hw/rtl/tpa_ctrl.sv @@
// controller: handshake sequencing and output valid
`timescale 1ns / 1ps
`default_nettype none
module tpa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output tpa_pkg::dp_cmd_t  dp_cmd
);
  import tpa_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    dp_cmd.capture = 1'b0;
    dp_cmd.commit  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready       = 1'b1;
        dp_cmd.capture = in_valid;
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        // wait until the output register is free
        dp_cmd.commit = !out_valid || out_ready;
        if (dp_cmd.commit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    if (dp_cmd.commit) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

endmodule
`default_nettype wire

@@ hw/rtl/tpa_datapath.sv @@
// datapath: timestamp queues, config registers, decision logic, result register
`timescale 1ns / 1ps
`default_nettype none
module tpa_datapath #(
  parameter int QUEUE_DEPTH = 256,
  parameter int STAMP_BITS  = 33
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tpa_pkg::dp_cmd_t              dp_cmd,
  input  logic [1:0]                    cmd,
  input  logic [STAMP_BITS-1:0]         stamp,
  input  logic                          cfg_we,
  input  logic [tpa_pkg::REG_IDX_W-1:0] cfg_addr,
  input  logic [tpa_pkg::CFG_W-1:0]     cfg_wdata,
  output logic [2:0]                    outcome,
  output logic [STAMP_BITS-1:0]         video_stamp,
  output logic [STAMP_BITS-1:0]         meta_stamp,
  output logic [tpa_pkg::FILL_W-1:0]    video_fill,
  output logic [tpa_pkg::FILL_W-1:0]    meta_fill
);
  import tpa_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int DW = (STAMP_BITS > TOL_W) ? STAMP_BITS : TOL_W;

  // config registers
  logic [TOL_W-1:0]     match_tol;
  logic [TIMEOUT_W-1:0] timeout;
  logic [LIMIT_W-1:0]   q_limit;

  // queue state
  logic [STAMP_BITS-1:0] vmem [QUEUE_DEPTH];
  logic [STAMP_BITS-1:0] mmem [QUEUE_DEPTH];
  logic [AW-1:0]         v_head, m_head;
  logic [CW-1:0]         v_count, m_count;
  logic [TIMEOUT_W-1:0]  idle;

  // captured transaction and head reads
  cmd_t                  cmd_r;
  logic [STAMP_BITS-1:0] stamp_r;
  logic [STAMP_BITS-1:0] v_front, m_front;

  logic [LW-1:0]         lim_ext, lim_eff;
  logic                  v_full, m_full;
  logic [AW:0]           v_sum, m_sum;
  logic [AW-1:0]         v_tail, m_tail;
  logic [STAMP_BITS-1:0] diff;
  logic                  in_tol;
  logic                  v_push, m_push, v_pop, m_pop, idle_clr, idle_inc;
  outcome_t              outcome_n;
  logic [STAMP_BITS-1:0] vs_n, ms_n;
  logic [CW-1:0]         v_count_next, m_count_next;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      match_tol <= TOL_RESET;
      timeout   <= TIMEOUT_RESET;
      q_limit   <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_addr))
        REG_MATCH_TOL:   match_tol <= cfg_wdata[TOL_W-1:0];
        REG_TIMEOUT:     timeout   <= cfg_wdata[TIMEOUT_W-1:0];
        REG_QUEUE_LIMIT: q_limit   <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective limit clamped to 1..QUEUE_DEPTH
  always_comb begin
    lim_ext = LW'(q_limit);
    if (lim_ext == '0) lim_eff = LW'(1);
    else if (lim_ext > LW'(QUEUE_DEPTH)) lim_eff = LW'(QUEUE_DEPTH);
    else lim_eff = lim_ext;
  end

  assign v_full = LW'(v_count) >= lim_eff;
  assign m_full = LW'(m_count) >= lim_eff;

  // tail slot, head plus count wrapped once
  assign v_sum  = (AW+1)'(v_head) + (AW+1)'(v_count);
  assign m_sum  = (AW+1)'(m_head) + (AW+1)'(m_count);
  assign v_tail = (v_sum >= (AW+1)'(QUEUE_DEPTH)) ?
                  AW'(v_sum - (AW+1)'(QUEUE_DEPTH)) : AW'(v_sum);
  assign m_tail = (m_sum >= (AW+1)'(QUEUE_DEPTH)) ?
                  AW'(m_sum - (AW+1)'(QUEUE_DEPTH)) : AW'(m_sum);

  assign diff   = (v_front >= m_front) ? v_front - m_front : m_front - v_front;
  assign in_tol = DW'(diff) <= DW'(match_tol);

  always_comb begin
    outcome_n = OUT_WAITING;
    vs_n      = '0;
    ms_n      = '0;
    v_push    = 1'b0;
    m_push    = 1'b0;
    v_pop     = 1'b0;
    m_pop     = 1'b0;
    idle_clr  = 1'b0;
    idle_inc  = 1'b0;
    case (cmd_r)
      CMD_PUSH_VIDEO: begin
        v_push    = 1'b1;
        outcome_n = OUT_PUSHED;
        if (v_full) begin
          v_pop     = 1'b1;
          vs_n      = v_front;
          outcome_n = OUT_PUSHED_DROP;
        end
      end
      CMD_PUSH_META: begin
        m_push    = 1'b1;
        outcome_n = OUT_PUSHED;
        if (m_full) begin
          m_pop     = 1'b1;
          ms_n      = m_front;
          outcome_n = OUT_PUSHED_DROP;
        end
      end
      CMD_TICK: begin
        idle_inc  = 1'b1;
        outcome_n = OUT_TICK;
      end
      CMD_STEP: begin
        if (v_count != '0) begin
          if (m_count != '0) begin
            if (in_tol) begin
              v_pop     = 1'b1;
              m_pop     = 1'b1;
              vs_n      = v_front;
              ms_n      = m_front;
              idle_clr  = 1'b1;
              outcome_n = OUT_MATCHED;
            end else if (v_front < m_front) begin
              v_pop     = 1'b1;
              vs_n      = v_front;
              outcome_n = OUT_VIDEO_DROP;
            end else begin
              m_pop     = 1'b1;
              ms_n      = m_front;
              idle_clr  = 1'b1;
              outcome_n = OUT_META_DROP;
            end
          end else if (idle > timeout) begin
            v_pop     = 1'b1;
            vs_n      = v_front;
            outcome_n = OUT_VIDEO_ALONE;
          end
        end
      end
      default: ;
    endcase
  end

  assign v_count_next = v_count + CW'(v_push) - CW'(v_pop);
  assign m_count_next = m_count + CW'(m_push) - CW'(m_pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_head  <= '0;
      m_head  <= '0;
      v_count <= '0;
      m_count <= '0;
      idle    <= '0;
    end else if (dp_cmd.commit) begin
      if (v_pop) v_head <= ptr_inc(v_head);
      if (m_pop) m_head <= ptr_inc(m_head);
      v_count <= v_count_next;
      m_count <= m_count_next;
      if (idle_clr) idle <= '0;
      else if (idle_inc && idle != IDLE_MAX) idle <= idle + TIMEOUT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      cmd_r   <= cmd_t'(cmd);
      stamp_r <= stamp;
    end
    if (dp_cmd.commit) begin
      outcome     <= outcome_n;
      video_stamp <= vs_n;
      meta_stamp  <= ms_n;
      video_fill  <= FILL_W'(v_count_next);
      meta_fill   <= FILL_W'(m_count_next);
    end
  end

  // head reads happen on capture, writes at the tail on commit
  always_ff @(posedge clk) begin
    if (dp_cmd.capture) v_front <= vmem[v_head];
    if (dp_cmd.commit && v_push) vmem[v_tail] <= stamp_r;
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.capture) m_front <= mmem[m_head];
    if (dp_cmd.commit && m_push) mmem[m_tail] <= stamp_r;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (v_count <= CW'(QUEUE_DEPTH)) && (m_count <= CW'(QUEUE_DEPTH)))
    else $error("queue count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.commit && cmd_r == CMD_PUSH_VIDEO && !v_full
    |=> v_count == $past(v_count) + CW'(1))
    else $error("video push without overflow did not grow the queue");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.commit && (outcome_n == OUT_MATCHED || outcome_n == OUT_META_DROP)
    |=> idle == '0)
    else $error("idle counter not cleared by metadata event");

  a_fill_tracks: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.commit |=> video_fill == FILL_W'(v_count) && meta_fill == FILL_W'(m_count))
    else $error("reported fill differs from queue count");

endmodule
`default_nettype wire

@@ hw/rtl/timestamp_pair_aligner.sv @@
// a transaction is accepted only in the idle state, which captures it and reads both
// queue heads from the synchronous memories; the execute state then commits the decision
// into the result register and raises out_valid; no new transaction is accepted before that
// a pending result stalls the commit cycle until it is taken
// reset: queues empty, idle count zero, config at defaults; queue memories are not cleared
`timescale 1ns / 1ps
`default_nettype none
module timestamp_pair_aligner #(
  parameter int QUEUE_DEPTH = 256,
  parameter int STAMP_BITS  = 33
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    cmd,
  input  logic [STAMP_BITS-1:0]         stamp,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    outcome,
  output logic [STAMP_BITS-1:0]         video_stamp,
  output logic [STAMP_BITS-1:0]         meta_stamp,
  output logic [tpa_pkg::FILL_W-1:0]    video_fill,
  output logic [tpa_pkg::FILL_W-1:0]    meta_fill,
  input  logic                          cfg_we,
  input  logic [tpa_pkg::REG_IDX_W-1:0] cfg_addr,
  input  logic [tpa_pkg::CFG_W-1:0]     cfg_wdata
);
  import tpa_pkg::*;

  dp_cmd_t dp_cmd;

  tpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_cmd    (dp_cmd)
  );

  tpa_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .STAMP_BITS  (STAMP_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .dp_cmd      (dp_cmd),
    .cmd         (cmd),
    .stamp       (stamp),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .outcome     (outcome),
    .video_stamp (video_stamp),
    .meta_stamp  (meta_stamp),
    .video_fill  (video_fill),
    .meta_fill   (meta_fill)
  );

endmodule
`default_nettype wire
